// File: rtl/core/hrt_pkg.sv
package hrt_pkg;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] CRLF_MAX = 3'd4;

  localparam logic [2:0] KIND_PROTO   = 3'd0;
  localparam logic [2:0] KIND_VERSION = 3'd1;
  localparam logic [2:0] KIND_STATUS  = 3'd2;
  localparam logic [2:0] KIND_REASON  = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;
  localparam logic [2:0] KIND_DELIM   = 3'd6;
  localparam logic [2:0] KIND_PAST    = 3'd7;

  localparam logic [2:0] CL_NONE    = 3'd0;
  localparam logic [2:0] CL_PROTO   = 3'd1;
  localparam logic [2:0] CL_VERSION = 3'd2;
  localparam logic [2:0] CL_STATUS  = 3'd3;
  localparam logic [2:0] CL_KEY     = 3'd4;
  localparam logic [2:0] CL_VALUE   = 3'd5;

  localparam logic [1:0] OC_RUN   = 2'd0;
  localparam logic [1:0] OC_DONE  = 2'd1;
  localparam logic [1:0] OC_NOEND = 2'd2;
  localparam logic [1:0] OC_EMPTY = 2'd3;

  localparam logic REG_HEADER_LENGTH = 1'b0;

  typedef enum logic [6:0] {
    PH_PROTO   = 7'b0000001,
    PH_VERSION = 7'b0000010,
    PH_STATUS  = 7'b0000100,
    PH_REASON  = 7'b0001000,
    PH_KEY     = 7'b0010000,
    PH_VLEAD   = 7'b0100000,
    PH_VALUE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic [2:0] closes;
    logic       line_done;
    logic [1:0] outcome;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] closes;
    phase_t     phase;
  } tag_t;

  function automatic tag_t content_tag(phase_t ph, logic [7:0] b);
    tag_t t;
    t.closes = CL_NONE;
    t.phase  = ph;
    unique case (ph)
      PH_PROTO: begin
        if (b == CH_SLASH) begin
          t.kind = KIND_DELIM; t.closes = CL_PROTO; t.phase = PH_VERSION;
        end else begin
          t.kind = KIND_PROTO;
        end
      end
      PH_VERSION: begin
        if (b == CH_SPACE) begin
          t.kind = KIND_DELIM; t.closes = CL_VERSION; t.phase = PH_STATUS;
        end else begin
          t.kind = KIND_VERSION;
        end
      end
      PH_STATUS: begin
        if (b == CH_SPACE) begin
          t.kind = KIND_DELIM; t.closes = CL_STATUS; t.phase = PH_REASON;
        end else begin
          t.kind = KIND_STATUS;
        end
      end
      PH_REASON: t.kind = KIND_REASON;
      PH_KEY: begin
        if (b == CH_COLON) begin
          t.kind = KIND_DELIM; t.closes = CL_KEY; t.phase = PH_VLEAD;
        end else begin
          t.kind = KIND_KEY;
        end
      end
      PH_VLEAD: begin
        t.kind  = (b == CH_SPACE) ? KIND_DELIM : KIND_VALUE;
        t.phase = PH_VALUE;
      end
      default: begin
        t.kind  = KIND_VALUE;
        t.phase = PH_VALUE;
      end
    endcase
    return t;
  endfunction

  function automatic logic [2:0] close_code(phase_t ph);
    logic [2:0] c;
    unique case (ph)
      PH_PROTO:   c = CL_PROTO;
      PH_VERSION: c = CL_VERSION;
      PH_STATUS:  c = CL_STATUS;
      PH_REASON:  c = CL_NONE;
      PH_KEY:     c = CL_KEY;
      default:    c = CL_VALUE;
    endcase
    return c;
  endfunction

  function automatic res_t make_res(logic [7:0] b, logic [2:0] kind, logic [2:0] closes,
                                    logic done);
    res_t r;
    r.data      = b;
    r.kind      = kind;
    r.closes    = closes;
    r.line_done = done;
    r.outcome   = OC_RUN;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/core/hrt_front.sv
module hrt_front
  import hrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] header_length,
  input  logic        in_valid,
  input  logic        in_start_of_message,
  input  logic [7:0]  in_data_byte,
  input  q_stat_t     q_stat,
  output logic        push,
  output entry_t      push_entry
);

  phase_t      phase_r, phase_nxt, ph_e;
  logic        held_r, held_nxt, held_e;
  logic        le_r, le_nxt, le_e;
  logic [2:0]  run_r, run_nxt, run_e, run_inc;
  logic [15:0] cnt_r, cnt_nxt, cnt_e, cnt_inc;
  logic        fin_r, fin_nxt, fin_e;
  logic        accept, scan, ending;
  logic [1:0]  n;
  logic [1:0]  oc;
  logic [7:0]  b;
  tag_t        t_cr, t_b, t_bc;
  res_t        r0, r1;

  assign accept = in_valid && !q_stat.full;
  assign b      = in_data_byte;
  assign scan   = (header_length == 16'd0);

  always_comb begin
    ph_e   = in_start_of_message ? PH_PROTO : phase_r;
    held_e = in_start_of_message ? 1'b0 : held_r;
    le_e   = in_start_of_message ? 1'b1 : le_r;
    run_e  = in_start_of_message ? 3'd0 : run_r;
    cnt_e  = in_start_of_message ? 16'd0 : cnt_r;
    fin_e  = in_start_of_message ? 1'b0 : fin_r;

    phase_nxt = ph_e;
    held_nxt  = held_e;
    le_nxt    = le_e;
    run_nxt   = run_e;
    cnt_nxt   = cnt_e;
    fin_nxt   = fin_e;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    oc = OC_RUN;

    t_cr = content_tag(ph_e, CH_CR);
    t_b  = content_tag(ph_e, b);
    t_bc = content_tag(t_cr.phase, b);

    if (b == CH_CR || b == CH_LF) begin
      run_inc = (run_e == CRLF_MAX) ? run_e : run_e + 3'd1;
    end else begin
      run_inc = 3'd0;
    end
    cnt_inc = (cnt_e == 16'hffff) ? cnt_e : cnt_e + 16'd1;
    ending  = scan ? (run_inc >= CRLF_MAX) : (cnt_inc >= header_length);

    if (fin_e) begin
      r0 = make_res(b, KIND_PAST, CL_NONE, 1'b0);
      n  = 2'd1;
    end else if (scan && b == CH_NUL) begin
      fin_nxt = 1'b1;
      oc = (cnt_e == 16'd0) ? OC_EMPTY : OC_NOEND;
      if (held_e) begin
        r0 = make_res(CH_CR, t_cr.kind, t_cr.closes, 1'b0);
        r1 = make_res(b, KIND_PAST, CL_NONE, 1'b0);
        phase_nxt = t_cr.phase;
        le_nxt    = 1'b0;
        held_nxt  = 1'b0;
        n = 2'd2;
      end else begin
        r0 = make_res(b, KIND_PAST, CL_NONE, 1'b0);
        n  = 2'd1;
      end
    end else begin
      run_nxt = run_inc;
      cnt_nxt = cnt_inc;
      if (held_e && b == CH_LF) begin
        held_nxt = 1'b0;
        r0 = make_res(CH_CR, KIND_DELIM, CL_NONE, 1'b0);
        n  = 2'd2;
        if (le_e) begin
          r1 = make_res(b, KIND_DELIM, CL_NONE, 1'b0);
          oc = OC_DONE;
          fin_nxt = 1'b1;
        end else begin
          r1 = make_res(b, KIND_DELIM, close_code(ph_e), 1'b1);
          phase_nxt = PH_KEY;
          le_nxt    = 1'b1;
        end
      end else if (held_e) begin
        r0 = make_res(CH_CR, t_cr.kind, t_cr.closes, 1'b0);
        le_nxt    = 1'b0;
        phase_nxt = t_cr.phase;
        if (b == CH_CR && !ending) begin
          held_nxt = 1'b1;
          n = 2'd1;
        end else begin
          r1 = make_res(b, t_bc.kind, t_bc.closes, 1'b0);
          phase_nxt = t_bc.phase;
          held_nxt  = 1'b0;
          n = 2'd2;
        end
      end else if (b == CH_CR && !ending) begin
        held_nxt = 1'b1;
      end else begin
        r0 = make_res(b, t_b.kind, t_b.closes, 1'b0);
        phase_nxt = t_b.phase;
        le_nxt    = 1'b0;
        n = 2'd1;
      end
      if (ending && !fin_nxt) begin
        oc = OC_NOEND;
        fin_nxt = 1'b1;
      end
    end

    if (n == 2'd2) begin
      r1.outcome = oc;
      r1.last    = 1'b1;
    end else if (n == 2'd1) begin
      r0.outcome = oc;
      r0.last    = 1'b1;
    end
  end

  assign push           = accept && (n != 2'd0);
  assign push_entry.r0  = r0;
  assign push_entry.r1  = r1;
  assign push_entry.two = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PROTO;
      held_r  <= 1'b0;
      le_r    <= 1'b1;
      run_r   <= 3'd0;
      cnt_r   <= 16'd0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      le_r    <= le_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// File: rtl/core/hrt_queue.sv
module hrt_queue
  import hrt_pkg::*;
#(
  parameter int Depth = 4
)(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  pop_entry,
  output q_stat_t stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r, count_nxt;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count_r == CntW'(Depth));
  assign stat.empty = (count_r == '0);
  assign pop_entry  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// File: rtl/core/hrt_back.sv
module hrt_back
  import hrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  entry_t  pop_entry,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output res_t    out_res
);

  entry_t cur_r;
  logic   valid_r, idx_r;
  logic   fire, done;

  assign fire      = valid_r && !out_stall;
  assign done      = fire && (idx_r || !cur_r.two);
  assign pop       = (!valid_r || done) && !q_stat.empty;
  assign out_valid = valid_r;
  assign out_res   = idx_r ? cur_r.r1 : cur_r.r0;

  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
      idx_r   <= 1'b0;
    end else if (done) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (fire) begin
      idx_r   <= 1'b1;
    end
  end

endmodule

// File: rtl/core/http_response_header_tagger.sv
// HTTP response header tagger.
// Input channel (in_valid / in_stall): one header byte per item, with
// in_start_of_message high on the first byte of a new header.
// Output channel (out_valid / out_stall): zero, one or two tagged result
// items per input byte, in order; out_last_result marks the final result of
// each byte and out_outcome reports completion on it.
// Config: APB write of header_length at address 0 (0 selects scan mode);
// pready is tied high. Write only while no item is in flight.
// Throughput: one byte accepted per cycle unless the result queue is full.
// The output drains one result per cycle while out_stall is low, so a byte
// with two results occupies the output for both; the result queue absorbs
// short bursts of these, a steady run of them slows the input.
// Results pass through the result queue into the output register (out_valid).
// in_stall rises when the result queue (QUEUE_DEPTH entries) is full.
// A stalled output holds its result; the front keeps accepting until the
// queue fills.
// Reset (synchronous, rst_n low): parse state cleared, queue emptied,
// header_length set to 0.
module http_response_header_tagger
  import hrt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_message,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic [2:0]  out_field_kind,
  output logic [2:0]  out_closes_field,
  output logic        out_line_done,
  output logic [1:0]  out_outcome,
  output logic        out_last_result
);

  logic [15:0] header_length_r;
  q_stat_t     q_stat;
  logic        push, pop;
  entry_t      push_entry, pop_entry;
  res_t        out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEADER_LENGTH) ? {16'd0, header_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_length_r <= 16'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER_LENGTH) begin
      header_length_r <= pwdata[15:0];
    end
  end

  assign in_stall = q_stat.full;

  hrt_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .header_length       (header_length_r),
    .in_valid            (in_valid),
    .in_start_of_message (in_start_of_message),
    .in_data_byte        (in_data_byte),
    .q_stat              (q_stat),
    .push                (push),
    .push_entry          (push_entry)
  );

  hrt_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  hrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_out_byte     = out_res.data;
  assign out_field_kind   = out_res.kind;
  assign out_closes_field = out_res.closes;
  assign out_line_done    = out_res.line_done;
  assign out_outcome      = out_res.outcome;
  assign out_last_result  = out_res.last;

endmodule

// File: tb/tb_http_response_header_tagger.sv
`timescale 1ns / 100ps

module tb_http_response_header_tagger;
  import hrt_pkg::*;

  localparam int LIMIT     = 500000;
  localparam int DIR_N     = 27;
  localparam int N_PHASE   = 8;
  localparam int PHASE_LEN = 180;

  typedef struct packed {
    logic       som;
    logic [7:0] data;
    logic       fixed;
    res_t       want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_start_of_message = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_out_byte;
  logic [2:0]  out_field_kind;
  logic [2:0]  out_closes_field;
  logic        out_line_done;
  logic [1:0]  out_outcome;
  logic        out_last_result;

  res_t        tags_due[$];
  logic [8:0]  pend_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  // tagger state
  logic [15:0] hlen;
  phase_t      ph;
  logic        held;
  logic        lempty;
  logic [2:0]  crlf;
  logic [15:0] bcount;
  logic        fin;

  http_response_header_tagger u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_of_message (in_start_of_message),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_byte        (out_out_byte),
    .out_field_kind      (out_field_kind),
    .out_closes_field    (out_closes_field),
    .out_line_done       (out_line_done),
    .out_outcome         (out_outcome),
    .out_last_result     (out_last_result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_out_byte, out_field_kind, out_closes_field, out_line_done, out_outcome,
              out_last_result};
      if (tags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: byte %h kind %0d closes %0d", got.data, got.kind,
                   got.closes);
      end else begin
        want = tags_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp byte %h kind %0d closes %0d done %b outcome %0d last %b",
                     want.data, want.kind, want.closes, want.line_done, want.outcome,
                     want.last);
            $display("          got byte %h kind %0d closes %0d done %b outcome %0d last %b",
                     got.data, got.kind, got.closes, got.line_done, got.outcome,
                     got.last);
          end
        end
      end
    end
  end

  function automatic res_t res_of(input logic [7:0] b, input logic [2:0] k,
                                  input logic [2:0] c, input logic d);
    res_t r;
    r = '{b, k, c, d, OC_RUN, 1'b0};
    return r;
  endfunction

  function automatic void restart_parse();
    ph     = PH_PROTO;
    held   = 1'b0;
    lempty = 1'b1;
    crlf   = '0;
    bcount = '0;
    fin    = 1'b0;
  endfunction

  function automatic logic [2:0] open_field();
    logic [2:0] c;
    case (ph)
      PH_PROTO:   c = CL_PROTO;
      PH_VERSION: c = CL_VERSION;
      PH_STATUS:  c = CL_STATUS;
      PH_REASON:  c = CL_NONE;
      PH_KEY:     c = CL_KEY;
      default:    c = CL_VALUE;
    endcase
    return c;
  endfunction

  function automatic res_t tag_content(input logic [7:0] b);
    logic [2:0] k;
    logic [2:0] c;
    k = KIND_VALUE;
    c = CL_NONE;
    lempty = 1'b0;
    case (ph)
      PH_PROTO: begin
        if (b == CH_SLASH) begin
          k = KIND_DELIM; c = CL_PROTO; ph = PH_VERSION;
        end else begin
          k = KIND_PROTO;
        end
      end
      PH_VERSION: begin
        if (b == CH_SPACE) begin
          k = KIND_DELIM; c = CL_VERSION; ph = PH_STATUS;
        end else begin
          k = KIND_VERSION;
        end
      end
      PH_STATUS: begin
        if (b == CH_SPACE) begin
          k = KIND_DELIM; c = CL_STATUS; ph = PH_REASON;
        end else begin
          k = KIND_STATUS;
        end
      end
      PH_REASON: k = KIND_REASON;
      PH_KEY: begin
        if (b == CH_COLON) begin
          k = KIND_DELIM; c = CL_KEY; ph = PH_VLEAD;
        end else begin
          k = KIND_KEY;
        end
      end
      PH_VLEAD: begin
        k  = (b == CH_SPACE) ? KIND_DELIM : KIND_VALUE;
        ph = PH_VALUE;
      end
      default: begin
        k  = KIND_VALUE;
        ph = PH_VALUE;
      end
    endcase
    return res_of(b, k, c, 1'b0);
  endfunction

  task automatic tag_byte(input logic som, input logic [7:0] b, output res_t r [2],
                          output int n);
    logic       ending;
    logic [1:0] oc;
    n  = 0;
    oc = OC_RUN;
    if (som)
      restart_parse();
    if (fin) begin
      r[0] = res_of(b, KIND_PAST, CL_NONE, 1'b0);
      r[0].last = 1'b1;
      n = 1;
      return;
    end
    if (hlen == 0 && b == CH_NUL) begin
      if (held) begin
        r[0] = tag_content(CH_CR);
        n = 1;
        held = 1'b0;
      end
      r[n] = res_of(b, KIND_PAST, CL_NONE, 1'b0);
      r[n].outcome = (bcount == 0) ? OC_EMPTY : OC_NOEND;
      r[n].last = 1'b1;
      n++;
      fin = 1'b1;
      return;
    end
    if (b == CH_CR || b == CH_LF) begin
      if (crlf < CRLF_MAX)
        crlf++;
    end else begin
      crlf = '0;
    end
    if (bcount != 16'hffff)
      bcount++;
    ending = (hlen == 0) ? (crlf >= CRLF_MAX) : (bcount >= hlen);
    if (held && b == CH_LF) begin
      held = 1'b0;
      r[0] = res_of(CH_CR, KIND_DELIM, CL_NONE, 1'b0);
      if (lempty) begin
        r[1] = res_of(b, KIND_DELIM, CL_NONE, 1'b0);
        oc = OC_DONE;
        fin = 1'b1;
      end else begin
        r[1] = res_of(b, KIND_DELIM, open_field(), 1'b1);
        ph = PH_KEY;
        lempty = 1'b1;
      end
      n = 2;
    end else begin
      if (held) begin
        held = 1'b0;
        r[n] = tag_content(CH_CR);
        n++;
      end
      if (b == CH_CR && !ending) begin
        held = 1'b1;
      end else begin
        r[n] = tag_content(b);
        n++;
      end
    end
    if (ending && !fin) begin
      oc = OC_NOEND;
      fin = 1'b1;
    end
    if (n > 0) begin
      r[n-1].outcome = oc;
      r[n-1].last = 1'b1;
    end
  endtask

  task automatic send_byte(input logic som, input logic [7:0] b, input logic fixed,
                           input res_t want);
    res_t r [2];
    int   n;
    int   i;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_message <= som;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    tag_byte(som, b, r, n);
    if (fixed)
      tags_due.push_back(want);
    else
      for (i = 0; i < n; i++)
        tags_due.push_back(r[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tags_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HEADER_LENGTH, 2'b00};
    pwdata  <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hlen = v;
  endtask

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      pend_q.push_back({1'b0, s[i]});
  endfunction

  function automatic void add_letters(input int lo, input int hi);
    int i;
    int len;
    len = $urandom_range(hi, lo);
    for (i = 0; i < len; i++)
      pend_q.push_back({1'b0, 8'($urandom_range(8'h7a, 8'h61))});
  endfunction

  // mostly well-formed responses, some noise, broken lines, NULs and flipped bytes
  function automatic void compose_message();
    int first;
    int i;
    int j;
    int len;
    logic [7:0] c;
    first = pend_q.size();
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(20, 1);
      for (i = 0; i < len; i++)
        pend_q.push_back({1'b0, 8'($urandom)});
    end else begin
      if ($urandom_range(7) == 0)
        add_text("HTTP/1.0 ");
      else
        add_text("HTTP/1.1 ");
      for (i = 0; i < 3; i++)
        pend_q.push_back({1'b0, 8'($urandom_range(8'h39, 8'h30))});
      add_text(" ");
      add_letters(1, 6);
      if ($urandom_range(3) == 0) begin
        add_text(" ");
        add_letters(1, 4);
      end
      pend_q.push_back({1'b0, CH_CR});
      pend_q.push_back({1'b0, CH_LF});
      len = $urandom_range(4, 0);
      for (i = 0; i < len; i++) begin
        add_letters(1, 8);
        if ($urandom_range(9) != 0)
          pend_q.push_back({1'b0, CH_COLON});
        if ($urandom_range(1) != 0)
          pend_q.push_back({1'b0, CH_SPACE});
        for (j = $urandom_range(10, 0); j > 0; j--) begin
          case ($urandom_range(19))
            0:       c = CH_CR;
            1:       c = CH_LF;
            2:       c = CH_COLON;
            default: c = 8'($urandom_range(126, 32));
          endcase
          pend_q.push_back({1'b0, c});
        end
        pend_q.push_back({1'b0, CH_CR});
        pend_q.push_back({1'b0, CH_LF});
      end
      if ($urandom_range(9) != 0) begin
        pend_q.push_back({1'b0, CH_CR});
        pend_q.push_back({1'b0, CH_LF});
      end
    end
    for (i = first; i < pend_q.size(); i++)
      if ($urandom_range(49) == 0)
        pend_q[i] = {pend_q[i][8], 8'($urandom)};
    if ($urandom_range(14) == 0) begin
      i = $urandom_range(pend_q.size() - 1, first);
      pend_q[i] = {pend_q[i][8], CH_NUL};
    end
    if ($urandom_range(9) != 0)
      pend_q[first] = {1'b1, pend_q[first][7:0]};
  endfunction

  initial begin
    step_t       dir_tab [DIR_N];
    int          gap_tab [N_PHASE];
    int          stall_tab [N_PHASE];
    logic [15:0] len_tab [N_PHASE];
    logic [8:0]  cur;
    int          p;
    int          k;

    dir_tab = '{
      '{1'b1, CH_NUL,   1'b1, '{CH_NUL, KIND_PAST, CL_NONE, 1'b0, OC_EMPTY, 1'b1}},
      '{1'b0, 8'hff,    1'b1, '{8'hff, KIND_PAST, CL_NONE, 1'b0, OC_RUN, 1'b1}},
      '{1'b1, "H",      1'b1, '{"H", KIND_PROTO, CL_NONE, 1'b0, OC_RUN, 1'b1}},
      '{1'b0, CH_SLASH, 1'b1, '{CH_SLASH, KIND_DELIM, CL_PROTO, 1'b0, OC_RUN, 1'b1}},
      '{1'b0, "1",      1'b0, '0},
      '{1'b0, CH_SPACE, 1'b0, '0},
      '{1'b0, "2",      1'b0, '0},
      '{1'b0, CH_SPACE, 1'b0, '0},
      '{1'b0, "O",      1'b0, '0},
      '{1'b0, CH_CR,    1'b0, '0},
      '{1'b0, "x",      1'b0, '0},
      '{1'b0, CH_CR,    1'b0, '0},
      '{1'b0, CH_LF,    1'b0, '0},
      '{1'b0, "K",      1'b0, '0},
      '{1'b0, CH_LF,    1'b0, '0},
      '{1'b0, CH_COLON, 1'b0, '0},
      '{1'b0, 8'hff,    1'b0, '0},
      '{1'b0, CH_CR,    1'b0, '0},
      '{1'b1, "Z",      1'b1, '{"Z", KIND_PROTO, CL_NONE, 1'b0, OC_RUN, 1'b1}},
      '{1'b0, CH_CR,    1'b0, '0},
      '{1'b0, CH_NUL,   1'b0, '0},
      '{1'b1, CH_CR,    1'b0, '0},
      '{1'b0, CH_LF,    1'b0, '0},
      '{1'b1, CH_LF,    1'b0, '0},
      '{1'b0, CH_CR,    1'b0, '0},
      '{1'b0, CH_LF,    1'b0, '0},
      '{1'b0, CH_CR,    1'b0, '0}
    };
    gap_tab   = '{0, 67, 0, 8, 0, 67, 0, 8};
    stall_tab = '{0, 0, 67, 8, 0, 0, 67, 8};
    len_tab   = '{16'd0, 16'hffff, 16'd16, 16'd1, 16'($urandom_range(80, 2)), 16'd0,
                  16'($urandom_range(200, 1)), 16'd0};

    hlen = '0;
    restart_parse();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scan mode from reset
    for (k = 0; k < DIR_N; k++)
      send_byte(dir_tab[k].som, dir_tab[k].data, dir_tab[k].fixed, dir_tab[k].want);

    // messages run across phase boundaries, so length changes land mid-header
    for (p = 0; p < N_PHASE; p++) begin
      settle();
      set_length(len_tab[p]);
      gap_pct = gap_tab[p];
      stall_pct <= stall_tab[p];
      for (k = 0; k < PHASE_LEN; k++) begin
        if (p == 4 && k == PHASE_LEN / 2)
          settle();
        if (pend_q.size() == 0)
          compose_message();
        cur = pend_q.pop_front();
        send_byte(cur[8], cur[7:0], 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && tags_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/hrt_pkg.sv
rtl/core/hrt_front.sv
rtl/core/hrt_queue.sv
rtl/core/hrt_back.sv
rtl/core/http_response_header_tagger.sv
tb/tb_http_response_header_tagger.sv
